// ===== src/calendar_date_add_sub_days_unit_macros.svh =====
// Assertion macros shared by the date add/subtract unit.
`ifndef CALENDAR_DATE_ADD_SUB_DAYS_UNIT_MACROS_SVH
`define CALENDAR_DATE_ADD_SUB_DAYS_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CDAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CDAS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/cdas_pkg.sv =====
// Constants, status codes and calendar functions for the date add/subtract unit.
`timescale 1ns / 1ps

package cdas_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int STATUS_W = 2;

    // Result tdata: day, month, year, status from bit 0 up, padded to 32 bits
    localparam int OUT_FIELDS_W = DAY_W + MONTH_W + YEAR_W + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  LEAP_CYCLE  = YEAR_W'(400);
    localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   FEB_LEN     = DAY_W'(28);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_DATE  = 2'd1,
        STATUS_YEAR_OOR  = 2'd2
    } status_t;

    // Leap test on the year taken modulo 400 (value below 400).
    function automatic logic is_leap(input logic [YEAR_W-1:0] rem);
        logic century;
        century = (rem == YEAR_W'(100)) || (rem == YEAR_W'(200)) || (rem == YEAR_W'(300));
        return (rem[1:0] == 2'b00) && !century;
    endfunction

    // Days in a month; months outside 1..12 read as 31.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:                      len = leap ? (FEB_LEN + DAY_W'(1)) : FEB_LEN;
            4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
            default:                   len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

// ===== src/calendar_date_add_sub_days_unit.sv =====
// Gregorian date add/subtract unit: moves a date by a day count one month per cycle.
`timescale 1ns / 1ps

// Takes a start date, a day count and a direction on the slave stream and
// returns the moved date with a status on the master stream. One item is in
// work at a time and s_tready is low meanwhile. A subtractor first reduces
// the start year modulo 400 for the leap rule, and the date then moves in
// month steps, one per cycle through the month-length table and the count
// subtractor (about 2155 steps at most for a 16-bit count). A finished
// result sits in the output register, so a new item is taken while it
// waits. Status 1 flags an invalid start date, status 2 a year leaving
// 1..9999; both return the start date unchanged.
module calendar_date_add_sub_days_unit #(
    parameter int COUNT_BITS = cdas_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // start_day, start_month, start_year, day_count, command; zero padded
    input  logic [((24 + COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // result_day, result_month, result_year, status; zero padded
    output logic [cdas_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int DW = cdas_pkg::DAY_W;
    localparam int MW = cdas_pkg::MONTH_W;
    localparam int YW = cdas_pkg::YEAR_W;
    localparam int SW = cdas_pkg::STATUS_W;

    localparam int MONTH_LSB   = DW;
    localparam int YEAR_LSB    = MONTH_LSB + MW;
    localparam int COUNT_LSB   = YEAR_LSB + YW;
    localparam int COMMAND_LSB = COUNT_LSB + COUNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_STEP,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [DW-1:0]          start_day_reg;
    logic [MW-1:0]          start_month_reg;
    logic [YW-1:0]          start_year_reg;
    logic [DW-1:0]          day_reg;
    logic [MW-1:0]          month_reg;
    logic [YW-1:0]          year_reg;
    logic [YW-1:0]          rem_reg;
    logic [COUNT_BITS-1:0]  left_reg;
    logic                   back_reg;
    cdas_pkg::status_t      fin_status_reg;
    logic [DW-1:0]          out_day_reg;
    logic [MW-1:0]          out_month_reg;
    logic [YW-1:0]          out_year_reg;
    cdas_pkg::status_t      out_status_reg;
    logic                   m_tvalid_reg;

    logic                   in_accept;
    logic                   out_free;
    logic                   leap_cur;
    logic [DW-1:0]          dim_cur;
    logic [DW-1:0]          room;
    logic                   fwd_fits;
    logic                   bwd_fits;
    logic                   month_is_dec;
    logic                   month_is_jan;
    logic [YW-1:0]          rem_inc;
    logic [YW-1:0]          rem_dec;
    logic [MW-1:0]          prev_month;
    logic [DW-1:0]          dim_prev;
    logic                   start_bad;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(cdas_pkg::OUT_TDATA_W - cdas_pkg::OUT_FIELDS_W){1'b0}},
                        out_status_reg, out_year_reg, out_month_reg, out_day_reg};

    // Month arithmetic shared by the check and step states
    always_comb
    begin
        leap_cur     = cdas_pkg::is_leap(rem_reg);
        dim_cur      = cdas_pkg::month_len(month_reg, leap_cur);
        room         = dim_cur - day_reg;
        fwd_fits     = left_reg <= (COUNT_BITS)'(room);
        bwd_fits     = left_reg < (COUNT_BITS)'(day_reg);
        month_is_dec = (month_reg == cdas_pkg::MONTH_DEC);
        month_is_jan = (month_reg == cdas_pkg::MONTH_JAN);
        rem_inc      = (rem_reg == cdas_pkg::LEAP_CYCLE - YW'(1)) ? '0 : rem_reg + YW'(1);
        rem_dec      = (rem_reg == '0) ? cdas_pkg::LEAP_CYCLE - YW'(1) : rem_reg - YW'(1);
        prev_month   = month_is_jan ? cdas_pkg::MONTH_DEC : month_reg - MW'(1);
        dim_prev     = cdas_pkg::month_len(prev_month,
                                           cdas_pkg::is_leap(month_is_jan ? rem_dec : rem_reg));
        start_bad    = (month_reg < cdas_pkg::MONTH_JAN) || (month_reg > cdas_pkg::MONTH_DEC) ||
                       (year_reg < cdas_pkg::YEAR_MIN) || (year_reg > cdas_pkg::YEAR_MAX) ||
                       (day_reg == '0) || (day_reg > dim_cur);
    end

    // Sequencer, working registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once taken; the finish state reloads it itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        start_day_reg   <= s_tdata[DW-1:0];
                        start_month_reg <= s_tdata[MONTH_LSB +: MW];
                        start_year_reg  <= s_tdata[YEAR_LSB +: YW];
                        day_reg         <= s_tdata[DW-1:0];
                        month_reg       <= s_tdata[MONTH_LSB +: MW];
                        year_reg        <= s_tdata[YEAR_LSB +: YW];
                        rem_reg         <= s_tdata[YEAR_LSB +: YW];
                        left_reg        <= s_tdata[COUNT_LSB +: COUNT_BITS];
                        back_reg        <= s_tdata[COMMAND_LSB];
                        state_reg       <= ST_REDUCE;
                    end
                end

                ST_REDUCE:
                begin
                    // Take the year modulo 400, one subtraction a cycle
                    if (rem_reg >= cdas_pkg::LEAP_CYCLE)
                    begin
                        rem_reg <= rem_reg - cdas_pkg::LEAP_CYCLE;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    if (start_bad)
                    begin
                        fin_status_reg <= cdas_pkg::STATUS_BAD_DATE;
                        state_reg      <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_STEP;
                    end
                end

                ST_STEP:
                begin
                    if (!back_reg)
                    begin
                        // Advance: finish inside this month or roll to the next
                        if (fwd_fits)
                        begin
                            day_reg        <= day_reg + left_reg[DW-1:0];
                            left_reg       <= '0;
                            fin_status_reg <= cdas_pkg::STATUS_OK;
                            state_reg      <= ST_FINISH;
                        end
                        else
                        begin
                            left_reg <= left_reg - (COUNT_BITS)'(room);
                            day_reg  <= '0;
                            if (month_is_dec)
                            begin
                                month_reg <= cdas_pkg::MONTH_JAN;
                                if (year_reg >= cdas_pkg::YEAR_MAX)
                                begin
                                    fin_status_reg <= cdas_pkg::STATUS_YEAR_OOR;
                                    state_reg      <= ST_FINISH;
                                end
                                else
                                begin
                                    year_reg <= year_reg + YW'(1);
                                    rem_reg  <= rem_inc;
                                end
                            end
                            else
                            begin
                                month_reg <= month_reg + MW'(1);
                            end
                        end
                    end
                    else
                    begin
                        // Step back: finish inside this month or fall to the previous
                        if (bwd_fits)
                        begin
                            day_reg        <= day_reg - left_reg[DW-1:0];
                            left_reg       <= '0;
                            fin_status_reg <= cdas_pkg::STATUS_OK;
                            state_reg      <= ST_FINISH;
                        end
                        else
                        begin
                            left_reg  <= left_reg - (COUNT_BITS)'(day_reg);
                            month_reg <= prev_month;
                            day_reg   <= dim_prev;
                            if (month_is_jan)
                            begin
                                if (year_reg <= cdas_pkg::YEAR_MIN)
                                begin
                                    fin_status_reg <= cdas_pkg::STATUS_YEAR_OOR;
                                    state_reg      <= ST_FINISH;
                                end
                                else
                                begin
                                    year_reg <= year_reg - YW'(1);
                                    rem_reg  <= rem_dec;
                                end
                            end
                            else if (left_reg == (COUNT_BITS)'(day_reg))
                            begin
                                fin_status_reg <= cdas_pkg::STATUS_OK;
                                state_reg      <= ST_FINISH;
                            end
                        end
                    end
                end

                ST_FINISH:
                begin
                    // Load the output register once it is free
                    if (out_free)
                    begin
                        if (fin_status_reg == cdas_pkg::STATUS_OK)
                        begin
                            out_day_reg   <= day_reg;
                            out_month_reg <= month_reg;
                            out_year_reg  <= year_reg;
                        end
                        else
                        begin
                            out_day_reg   <= start_day_reg;
                            out_month_reg <= start_month_reg;
                            out_year_reg  <= start_year_reg;
                        end
                        out_status_reg <= fin_status_reg;
                        m_tvalid_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "calendar_date_add_sub_days_unit_macros.svh"

    `CDAS_ASSERT(a_rem_in_cycle, (state_reg == ST_STEP) |-> (rem_reg < cdas_pkg::LEAP_CYCLE), "year remainder not reduced below 400 while stepping")
    `CDAS_ASSERT(a_step_month_ok, (state_reg == ST_STEP) |-> ((month_reg >= cdas_pkg::MONTH_JAN) && (month_reg <= cdas_pkg::MONTH_DEC) && (day_reg <= dim_cur)), "month or day out of range while stepping")
    `CDAS_ASSERT(a_ok_result_valid, (m_tvalid_reg && (out_status_reg == cdas_pkg::STATUS_OK)) |-> ((out_month_reg >= cdas_pkg::MONTH_JAN) && (out_month_reg <= cdas_pkg::MONTH_DEC) && (out_day_reg != '0) && (out_year_reg >= cdas_pkg::YEAR_MIN) && (out_year_reg <= cdas_pkg::YEAR_MAX)), "ok result carries an invalid date")
    `CDAS_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> ((state_reg == ST_IDLE) && !m_tvalid_reg), "unit not idle during reset")

endmodule

// ===== tb/sv/tb_calendar_date_add_sub_days_unit.sv =====
// Self-checking testbench for the Gregorian date add/subtract unit.
`timescale 1ns / 1ps

module tb_calendar_date_add_sub_days_unit;

    localparam int CNT_W        = cdas_pkg::COUNT_BITS_DEFAULT;
    localparam int IN_W         = ((24 + CNT_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 245;
    localparam int QUIET_ITEMS  = 40;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 60;
    localparam bit DIR_FWD      = 1'b0;
    localparam bit DIR_BACK     = 1'b1;

    typedef struct packed {
        logic [cdas_pkg::DAY_W-1:0]   day;
        logic [cdas_pkg::MONTH_W-1:0] month;
        logic [cdas_pkg::YEAR_W-1:0]  year;
        logic [CNT_W-1:0]             count;
        logic                         back;
    } date_req_t;

    typedef struct packed {
        logic [cdas_pkg::DAY_W-1:0]   day;
        logic [cdas_pkg::MONTH_W-1:0] month;
        logic [cdas_pkg::YEAR_W-1:0]  year;
        cdas_pkg::status_t            status;
    } date_res_t;

    typedef struct {
        date_req_t req;
        bit        drain;
    } pending_item_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [IN_W-1:0]                  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [cdas_pkg::OUT_TDATA_W-1:0] m_tdata;

    pending_item_t pending_items[$];
    date_res_t     expected_dates[$];
    int            total_items;
    int            items_sent;
    int            items_recv;
    int            error_count;
    int            send_gap;
    int            recv_gap;
    int            stall_cycles;

    // Driver scratch
    date_req_t     cur_req;
    pending_item_t next_item;
    int            sent_now;

    // Monitor scratch
    date_res_t     want;
    date_res_t     got;

    calendar_date_add_sub_days_unit #(
        .COUNT_BITS (CNT_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Gregorian leap rule on the full year
    function automatic bit leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // Days in a month; out-of-range months read as 31
    function automatic int days_in(input int m, input int y);
        int len;
        case (m)
            2:             len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    // Walk the date one month at a time and return the moved date with status
    function automatic date_res_t predict_move(input date_req_t r);
        date_res_t         res;
        int                d;
        int                m;
        int                y;
        int                left;
        int                room;
        cdas_pkg::status_t st;
        d    = r.day;
        m    = r.month;
        y    = r.year;
        left = r.count;
        st   = cdas_pkg::STATUS_OK;
        if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1 || d > days_in(m, y))
        begin
            st = cdas_pkg::STATUS_BAD_DATE;
        end
        else if (r.back == DIR_FWD)
        begin
            while (left != 0 && st == cdas_pkg::STATUS_OK)
            begin
                room = days_in(m, y) - d;
                if (left <= room)
                begin
                    d    = d + left;
                    left = 0;
                end
                else
                begin
                    left = left - room;
                    d    = 0;
                    if (m == 12)
                    begin
                        m = 1;
                        if (y >= 9999) st = cdas_pkg::STATUS_YEAR_OOR;
                        else y = y + 1;
                    end
                    else
                    begin
                        m = m + 1;
                    end
                end
            end
        end
        else
        begin
            while (left != 0 && st == cdas_pkg::STATUS_OK)
            begin
                if (left < d)
                begin
                    d    = d - left;
                    left = 0;
                end
                else
                begin
                    left = left - d;
                    if (m == 1)
                    begin
                        m = 12;
                        if (y <= 1) st = cdas_pkg::STATUS_YEAR_OOR;
                        else y = y - 1;
                    end
                    else
                    begin
                        m = m - 1;
                    end
                    d = days_in(m, y);
                end
            end
        end
        // Errors hand back the start date
        if (st != cdas_pkg::STATUS_OK)
        begin
            d = r.day;
            m = r.month;
            y = r.year;
        end
        res.day    = cdas_pkg::DAY_W'(d);
        res.month  = cdas_pkg::MONTH_W'(m);
        res.year   = cdas_pkg::YEAR_W'(y);
        res.status = st;
        return res;
    endfunction

    // Queue one item for the driver
    task automatic add_item(input int d, input int m, input int y, input int cnt,
                            input bit dir, input bit drain);
        pending_item_t it;
        it.req.day   = cdas_pkg::DAY_W'(d);
        it.req.month = cdas_pkg::MONTH_W'(m);
        it.req.year  = cdas_pkg::YEAR_W'(y);
        it.req.count = CNT_W'(cnt);
        it.req.back  = dir;
        it.drain     = drain;
        pending_items.push_back(it);
    endtask

    // Pick a day count: mostly short moves, some up to the full range
    function automatic int pick_count();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $urandom_range(0, 62);
        if (sel < 7) return $urandom_range(0, 2000);
        return $urandom_range(0, (1 << CNT_W) - 1);
    endfunction

    // Driver: present pending items, hold on backpressure, idle in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            send_gap   <= 0;
            items_sent <= 0;
        end
        else
        begin
            sent_now = items_sent;
            if (s_tvalid && s_tready)
            begin
                expected_dates.push_back(predict_move(cur_req));
                sent_now = items_sent + 1;
                items_sent <= sent_now;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the item until taken
            end
            else if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() == 0 ||
                     (pending_items[0].drain && sent_now != items_recv))
            begin
                // nothing left, or wait for every result before this item
                s_tvalid <= 1'b0;
            end
            else if (sent_now < total_items - QUIET_ITEMS &&
                     $urandom_range(0, 4) == 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= $urandom_range(0, 6);
            end
            else
            begin
                next_item = pending_items.pop_front();
                cur_req   = next_item.req;
                s_tdata   <= IN_W'({cur_req.back, cur_req.count, cur_req.year,
                                    cur_req.month, cur_req.day});
                s_tvalid  <= 1'b1;
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_gap   <= 0;
            items_recv <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                items_recv <= items_recv + 1;
                got.day    = m_tdata[cdas_pkg::DAY_W-1:0];
                got.month  = m_tdata[cdas_pkg::DAY_W +: cdas_pkg::MONTH_W];
                got.year   = m_tdata[cdas_pkg::DAY_W+cdas_pkg::MONTH_W +: cdas_pkg::YEAR_W];
                got.status = cdas_pkg::status_t'(m_tdata[cdas_pkg::DAY_W+cdas_pkg::MONTH_W+
                                                         cdas_pkg::YEAR_W +: cdas_pkg::STATUS_W]);
                if (expected_dates.size() == 0)
                begin
                    $error("unexpected result: day %0d month %0d year %0d status %0d",
                           got.day, got.month, got.year, got.status);
                    error_count++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got.day !== want.day)
                    begin
                        $error("result_day: expected %0d, actual %0d", want.day, got.day);
                        error_count++;
                    end
                    if (got.month !== want.month)
                    begin
                        $error("result_month: expected %0d, actual %0d",
                               want.month, got.month);
                        error_count++;
                    end
                    if (got.year !== want.year)
                    begin
                        $error("result_year: expected %0d, actual %0d", want.year, got.year);
                        error_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (items_recv < total_items - QUIET_ITEMS &&
                     $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 6);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : stimulus
        int kind;
        int y;
        int m;
        rst_n       = 1'b0;
        error_count = 0;
        total_items = 1 << 30;

        // Zero count at both ends of the calendar
        add_item(1, 1, 1, 0, DIR_FWD, 1'b0);
        add_item(31, 12, 9999, 0, DIR_BACK, 1'b0);
        // Year leaving the range at either end
        add_item(31, 12, 9999, 1, DIR_FWD, 1'b0);
        add_item(1, 1, 1, 1, DIR_BACK, 1'b0);
        add_item(1, 1, 9999, 364, DIR_FWD, 1'b0);
        add_item(1, 1, 9999, 365, DIR_FWD, 1'b0);
        // Leap rule: 400-year leap, plain century, ordinary leap
        add_item(28, 2, 2000, 1, DIR_FWD, 1'b0);
        add_item(28, 2, 1900, 1, DIR_FWD, 1'b0);
        add_item(28, 2, 2004, 1, DIR_FWD, 1'b0);
        add_item(1, 3, 2100, 1, DIR_BACK, 1'b0);
        add_item(29, 2, 2000, 365, DIR_FWD, 1'b0);
        // Month and year rollovers
        add_item(31, 1, 2023, 1, DIR_FWD, 1'b0);
        add_item(1, 1, 2024, 1, DIR_BACK, 1'b0);
        // Invalid start dates
        add_item(29, 2, 1900, 5, DIR_FWD, 1'b0);
        add_item(0, 6, 2000, 5, DIR_FWD, 1'b0);
        add_item(31, 4, 2000, 5, DIR_BACK, 1'b0);
        add_item(10, 0, 2000, 5, DIR_FWD, 1'b0);
        add_item(10, 13, 2000, 5, DIR_FWD, 1'b0);
        add_item(31, 15, 16383, 65535, DIR_BACK, 1'b0);
        add_item(10, 5, 0, 5, DIR_FWD, 1'b0);
        add_item(10, 5, 10000, 5, DIR_BACK, 1'b0);
        // Full count in both directions, after the unit has drained
        add_item(1, 1, 1, 65535, DIR_FWD, 1'b1);
        add_item(31, 12, 9999, 65535, DIR_BACK, 1'b0);
        add_item(15, 6, 5000, 65535, DIR_FWD, 1'b0);
        add_item(15, 6, 5000, 65535, DIR_BACK, 1'b0);

        // Random part: valid dates, dates near the range ends, and noise
        repeat (RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                y = $urandom_range(1, 9999);
                m = $urandom_range(1, 12);
                add_item($urandom_range(1, days_in(m, y)), m, y, pick_count(),
                         1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0);
            end
            else if (kind < 85)
            begin
                y = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3)
                                                : $urandom_range(9997, 9999);
                m = $urandom_range(1, 12);
                add_item($urandom_range(1, days_in(m, y)), m, y,
                         $urandom_range(0, (1 << CNT_W) - 1),
                         1'($urandom_range(0, 1)), 1'b0);
            end
            else
            begin
                add_item($urandom_range(0, 31), $urandom_range(0, 15),
                         $urandom_range(0, (1 << cdas_pkg::YEAR_W) - 1),
                         $urandom_range(0, (1 << CNT_W) - 1),
                         1'($urandom_range(0, 1)), 1'b0);
            end
        end
        total_items = pending_items.size();

        // Hold reset, then release on a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item and result, then let the unit settle
        while (items_sent != total_items || items_recv != total_items)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_dates.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_dates.size());
        end
        if (error_count == 0 && expected_dates.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/cdas_pkg.sv
src/calendar_date_add_sub_days_unit.sv
tb/sv/tb_calendar_date_add_sub_days_unit.sv
